>>> rtl/gzhp_pkg.sv
// ----------------------------------------------------------------------------
// gzhp_pkg
// Shared types and constants for the gzip header parser.
// ----------------------------------------------------------------------------
package gzhp_pkg;

  // header byte counter width; the count saturates at all ones
  localparam int LEN_W = 20;

  localparam logic [7:0] MAGIC_ONE    = 8'h1F;
  localparam logic [7:0] MAGIC_TWO    = 8'h8B;
  localparam int         FLG_FHCRC    = 1;
  localparam int         FLG_FEXTRA   = 2;
  localparam int         FLG_FNAME    = 3;
  localparam int         FLG_FCOMMENT = 4;

  // byte offsets inside the fixed part and the dictzip subfield
  localparam logic [15:0] FIXED_XFL_POS  = 16'd4;
  localparam logic [15:0] FIXED_LEN      = 16'd6;
  localparam logic [15:0] RA_VER_LO      = 16'd4;
  localparam logic [15:0] RA_VER_HI      = 16'd5;
  localparam logic [15:0] RA_CLEN_LO     = 16'd6;
  localparam logic [15:0] RA_CLEN_HI     = 16'd7;
  localparam logic [15:0] RA_CCNT_LO     = 16'd8;
  localparam logic [15:0] RA_CCNT_HI     = 16'd9;
  localparam logic [15:0] RA_CHUNK_BASE  = 16'd10;
  localparam logic [15:0] HCRC_LEN       = 16'd2;
  // chunk index = (pos - base) / 2 + 1 = pos[15:1] - (base / 2 - 1)
  localparam logic [14:0] CHUNK_IDX_OFFS = 15'(RA_CHUNK_BASE / 2 - 1);

  typedef enum logic [1:0] {
    KIND_CHUNK     = 2'd0,
    KIND_DONE      = 2'd1,
    KIND_BAD_MAGIC = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [14:0]       chunk_index;
    logic [15:0]       chunk_size;
    logic [LEN_W-1:0]  header_length;
    logic [7:0]        flag_bits;
    logic [7:0]        method;
    logic [7:0]        extra_flags;
    logic [15:0]       ra_version;
    logic [15:0]       chunk_length;
    logic [15:0]       chunk_count;
  } result_t;

endpackage

>>> rtl/gzhp_if.sv
// ----------------------------------------------------------------------------
// gzhp_in_if / gzhp_out_if
// Valid/ready channels for stream bytes in and parse results out.
// ----------------------------------------------------------------------------
interface gzhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;

  modport source (output valid, output data_byte, output first, input ready);
  modport sink   (input valid, input data_byte, input first, output ready);
endinterface

interface gzhp_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [14:0]                 chunk_index;
  logic [15:0]                 chunk_size;
  logic [gzhp_pkg::LEN_W-1:0]  header_length;
  logic [7:0]                  flag_bits;
  logic [7:0]                  method;
  logic [7:0]                  extra_flags;
  logic [15:0]                 ra_version;
  logic [15:0]                 chunk_length;
  logic [15:0]                 chunk_count;

  modport source (
    output valid, output kind, output chunk_index, output chunk_size,
    output header_length, output flag_bits, output method, output extra_flags,
    output ra_version, output chunk_length, output chunk_count, input ready
  );
  modport sink (
    input valid, input kind, input chunk_index, input chunk_size,
    input header_length, input flag_bits, input method, input extra_flags,
    input ra_version, input chunk_length, input chunk_count, output ready
  );
endinterface

>>> rtl/gzhp_parse_core.sv
// ----------------------------------------------------------------------------
// gzhp_parse_core
// Header parse state and the per-byte update that yields at most one result.
// ----------------------------------------------------------------------------
module gzhp_parse_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                first,
  output logic                res_valid,
  output gzhp_pkg::result_t   res
);

  typedef enum logic [3:0] {
    PH_MAGIC1  = 4'd0,
    PH_MAGIC2  = 4'd1,
    PH_METHOD  = 4'd2,
    PH_FLAGS   = 4'd3,
    PH_FIXED   = 4'd4,
    PH_XLEN    = 4'd5,
    PH_EXTRA   = 4'd6,
    PH_NAME    = 4'd7,
    PH_COMMENT = 4'd8,
    PH_HCRC    = 4'd9,
    PH_REPORT  = 4'd10,
    PH_IDLE    = 4'd11
  } phase_t;

  phase_t                     phase, phase_next;
  logic [15:0]                field_position, field_position_next;
  logic [7:0]                 flags_held, flags_held_next;
  logic [7:0]                 method_held, method_held_next;
  logic [7:0]                 xfl_held, xfl_held_next;
  logic [15:0]                extra_length, extra_length_next;
  logic [7:0]                 low_byte_held, low_byte_held_next;
  logic [15:0]                version_held, version_held_next;
  logic [15:0]                chunk_length_held, chunk_length_held_next;
  logic [15:0]                chunk_count_held, chunk_count_held_next;
  logic [gzhp_pkg::LEN_W-1:0] length_count, length_count_next;

  logic [15:0] pos_inc;
  logic [14:0] chunk_idx;

  // first optional section at or after step k (0 extra .. 3 header crc)
  function automatic phase_t next_section(input logic [7:0] flg, input logic [2:0] k);
    phase_t ph;
    if (k == 3'd0 && flg[gzhp_pkg::FLG_FEXTRA]) begin
      ph = PH_XLEN;
    end else if (k <= 3'd1 && flg[gzhp_pkg::FLG_FNAME]) begin
      ph = PH_NAME;
    end else if (k <= 3'd2 && flg[gzhp_pkg::FLG_FCOMMENT]) begin
      ph = PH_COMMENT;
    end else if (k <= 3'd3 && flg[gzhp_pkg::FLG_FHCRC]) begin
      ph = PH_HCRC;
    end else begin
      ph = PH_REPORT;
    end
    return ph;
  endfunction

  always_comb begin
    phase_next             = phase;
    field_position_next    = field_position;
    flags_held_next        = flags_held;
    method_held_next       = method_held;
    xfl_held_next          = xfl_held;
    extra_length_next      = extra_length;
    low_byte_held_next     = low_byte_held;
    version_held_next      = version_held;
    chunk_length_held_next = chunk_length_held;
    chunk_count_held_next  = chunk_count_held;
    length_count_next      = length_count;

    // a first byte restarts the parse from a clean state
    if (first) begin
      phase_next             = PH_MAGIC1;
      field_position_next    = '0;
      flags_held_next        = '0;
      method_held_next       = '0;
      xfl_held_next          = '0;
      extra_length_next      = '0;
      low_byte_held_next     = '0;
      version_held_next      = '0;
      chunk_length_held_next = '0;
      chunk_count_held_next  = '0;
      length_count_next      = '0;
    end

    res_valid         = 1'b0;
    res               = '0;
    res.flag_bits     = flags_held_next;
    res.method        = method_held_next;
    res.extra_flags   = xfl_held_next;
    res.ra_version    = version_held_next;
    res.chunk_length  = chunk_length_held_next;
    res.chunk_count   = chunk_count_held_next;

    if (phase_next <= PH_HCRC && !(&length_count_next)) begin
      length_count_next = length_count_next + 1'b1;
    end

    pos_inc   = field_position_next + 16'd1;
    chunk_idx = field_position_next[15:1] - gzhp_pkg::CHUNK_IDX_OFFS;

    case (phase_next)
      PH_MAGIC1: begin
        if (data_byte == gzhp_pkg::MAGIC_ONE) begin
          phase_next = PH_MAGIC2;
        end else begin
          res_valid  = 1'b1;
          res        = '0;
          res.kind   = gzhp_pkg::KIND_BAD_MAGIC;
          phase_next = PH_IDLE;
        end
      end
      PH_MAGIC2: begin
        if (data_byte == gzhp_pkg::MAGIC_TWO) begin
          phase_next = PH_METHOD;
        end else begin
          res_valid  = 1'b1;
          res        = '0;
          res.kind   = gzhp_pkg::KIND_BAD_MAGIC;
          phase_next = PH_IDLE;
        end
      end
      PH_METHOD: begin
        method_held_next = data_byte;
        phase_next       = PH_FLAGS;
      end
      PH_FLAGS: begin
        flags_held_next     = data_byte;
        field_position_next = '0;
        phase_next          = PH_FIXED;
      end
      PH_FIXED: begin
        if (field_position_next == gzhp_pkg::FIXED_XFL_POS) begin
          xfl_held_next = data_byte;
        end
        field_position_next = pos_inc;
        if (pos_inc >= gzhp_pkg::FIXED_LEN) begin
          field_position_next = '0;
          phase_next          = next_section(flags_held_next, 3'd0);
        end
      end
      PH_XLEN: begin
        if (field_position_next == '0) begin
          extra_length_next   = {8'h00, data_byte};
          field_position_next = 16'd1;
        end else begin
          extra_length_next   = {data_byte, extra_length_next[7:0]};
          field_position_next = '0;
          if ({data_byte, extra_length_next[7:0]} == '0) begin
            phase_next = next_section(flags_held_next, 3'd1);
          end else begin
            phase_next = PH_EXTRA;
          end
        end
      end
      PH_EXTRA: begin
        case (field_position_next)
          gzhp_pkg::RA_VER_LO:  version_held_next[7:0]       = data_byte;
          gzhp_pkg::RA_VER_HI:  version_held_next[15:8]      = data_byte;
          gzhp_pkg::RA_CLEN_LO: chunk_length_held_next[7:0]  = data_byte;
          gzhp_pkg::RA_CLEN_HI: chunk_length_held_next[15:8] = data_byte;
          gzhp_pkg::RA_CCNT_LO: chunk_count_held_next[7:0]   = data_byte;
          gzhp_pkg::RA_CCNT_HI: chunk_count_held_next[15:8]  = data_byte;
          default: begin
            if (field_position_next >= gzhp_pkg::RA_CHUNK_BASE) begin
              // base is even, so bit 0 tells low byte from high byte
              if (!field_position_next[0]) begin
                low_byte_held_next = data_byte;
              end else if ({1'b0, chunk_idx} <= chunk_count_held_next) begin
                res_valid       = 1'b1;
                res.kind        = gzhp_pkg::KIND_CHUNK;
                res.chunk_index = chunk_idx;
                res.chunk_size  = {data_byte, low_byte_held_next};
              end
            end
          end
        endcase
        res.ra_version      = version_held_next;
        res.chunk_length    = chunk_length_held_next;
        res.chunk_count     = chunk_count_held_next;
        field_position_next = pos_inc;
        if (pos_inc >= extra_length_next) begin
          field_position_next = '0;
          phase_next          = next_section(flags_held_next, 3'd1);
        end
      end
      PH_NAME: begin
        if (data_byte == 8'h00) begin
          field_position_next = '0;
          phase_next          = next_section(flags_held_next, 3'd2);
        end
      end
      PH_COMMENT: begin
        if (data_byte == 8'h00) begin
          field_position_next = '0;
          phase_next          = next_section(flags_held_next, 3'd3);
        end
      end
      PH_HCRC: begin
        field_position_next = pos_inc;
        if (pos_inc >= gzhp_pkg::HCRC_LEN) begin
          field_position_next = '0;
          phase_next          = PH_REPORT;
        end
      end
      PH_REPORT: begin
        res_valid         = 1'b1;
        res.kind          = gzhp_pkg::KIND_DONE;
        res.header_length = length_count_next;
        phase_next        = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_MAGIC1;
      field_position    <= '0;
      flags_held        <= '0;
      method_held       <= '0;
      xfl_held          <= '0;
      extra_length      <= '0;
      low_byte_held     <= '0;
      version_held      <= '0;
      chunk_length_held <= '0;
      chunk_count_held  <= '0;
      length_count      <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      field_position    <= field_position_next;
      flags_held        <= flags_held_next;
      method_held       <= method_held_next;
      xfl_held          <= xfl_held_next;
      extra_length      <= extra_length_next;
      low_byte_held     <= low_byte_held_next;
      version_held      <= version_held_next;
      chunk_length_held <= chunk_length_held_next;
      chunk_count_held  <= chunk_count_held_next;
      length_count      <= length_count_next;
    end
  end

endmodule

>>> rtl/gzhp_out_stage.sv
// ----------------------------------------------------------------------------
// gzhp_out_stage
// Result register with a skid entry so the input side keeps flowing.
// ----------------------------------------------------------------------------
module gzhp_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  gzhp_pkg::result_t  push_data,
  output logic               can_push,
  gzhp_out_if.source         out_ch
);

  logic              main_valid;
  logic              skid_valid;
  gzhp_pkg::result_t main_data;
  gzhp_pkg::result_t skid_data;
  logic              pop;
  logic              main_load;

  assign pop       = main_valid && out_ch.ready;
  assign main_load = !main_valid || pop;
  assign can_push  = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_load) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_load) begin
      main_data <= skid_valid ? skid_data : push_data;
    end
    if (!main_load && push) begin
      skid_data <= push_data;
    end
  end

  assign out_ch.valid         = main_valid;
  assign out_ch.kind          = main_data.kind;
  assign out_ch.chunk_index   = main_data.chunk_index;
  assign out_ch.chunk_size    = main_data.chunk_size;
  assign out_ch.header_length = main_data.header_length;
  assign out_ch.flag_bits     = main_data.flag_bits;
  assign out_ch.method        = main_data.method;
  assign out_ch.extra_flags   = main_data.extra_flags;
  assign out_ch.ra_version    = main_data.ra_version;
  assign out_ch.chunk_length  = main_data.chunk_length;
  assign out_ch.chunk_count   = main_data.chunk_count;

endmodule

>>> rtl/gzip_header_parser_unit.sv
// a result is written to the output register, or to the skid entry while the sink waits
// throughput: one byte per cycle; the only stall is a full skid entry while the sink waits
// a byte that causes no result frees the next cycle at once
// reset (rst, synchronous): parse restarts at the first magic byte, all held fields and
// the header count clear, and the output register and skid entry empty
// ----------------------------------------------------------------------------
// gzip_header_parser_unit
// Byte-serial gzip header parser with dictzip random-access chunk table.
// ----------------------------------------------------------------------------
module gzip_header_parser_unit (
  input  logic        clk,
  input  logic        rst,
  gzhp_in_if.sink     in_ch,
  gzhp_out_if.source  out_ch
);

  // an input transaction updates the parse state and, at most, produces one result
  logic              accept;
  logic              can_push;
  logic              res_valid;
  gzhp_pkg::result_t res;

  // ready depends only on the skid entry, so a waiting result never blocks
  // the next byte while the skid entry is free
  assign in_ch.ready = can_push;
  assign accept      = in_ch.valid && can_push;

  // phase sequencer: magic, method, flags, fixed part, optional sections
  gzhp_parse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (in_ch.data_byte),
    .first     (in_ch.first),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register plus skid entry toward the sink
  gzhp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_data (res),
    .can_push  (can_push),
    .out_ch    (out_ch)
  );

endmodule
